/* hdl/sclr_pkg.sv */
// Shared constants, types and keyword tables for the serial command line reader.
// Used by sclr_matcher, serial_command_line_reader_unit and the testbench; depends on nothing.

package sclr_pkg;

    // Line store sizing: at most LINE_CAPACITY-1 characters are kept
    localparam int LINE_CAPACITY = 64;
    localparam int CNT_W         = $clog2(LINE_CAPACITY);
    localparam int LEN_W         = 6;
    localparam int LEN_MAX       = (1 << LEN_W) - 1;

    // Byte codes with a special meaning
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS  = 8'h20;

    // Result kinds
    localparam logic KIND_EOL      = 1'b0;
    localparam logic KIND_OVERFLOW = 1'b1;

    // Keyword matchers: version query, sensor on, sensor off
    localparam int KW_COUNT   = 3;
    localparam int KW_VER     = 0;
    localparam int KW_ON      = 1;
    localparam int KW_OFF     = 2;
    localparam int KW_MAX_LEN = 11;
    localparam int PROG_W     = 4;

    localparam logic [PROG_W-1:0] KW_LEN [KW_COUNT] = '{4'd3, 4'd10, 4'd11};

    // Keyword text as character codes, unused tail bytes zero
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{8'h56, 8'h45, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h53, 8'h31, 8'h38, 8'h42, 8'h32, 8'h30, 8'h5F, 8'h4F, 8'h4E, 8'h00},
        '{8'h44, 8'h53, 8'h31, 8'h38, 8'h42, 8'h32, 8'h30, 8'h5F, 8'h4F, 8'h46, 8'h46}
    };

    // Control from the line tracker to the matchers
    typedef struct packed {
        logic feed;
        logic clear;
    } match_ctrl_t;

    // One result item
    typedef struct packed {
        logic             kind;
        logic [LEN_W-1:0] length;
        logic             version;
        logic             sensor;
    } result_t;

endpackage

/* hdl/sclr_matcher.sv */
// Streaming keyword matchers, one lane per keyword, with a seen flag each.
// Depends on sclr_pkg for the keyword tables and the control struct.

module sclr_matcher
    import sclr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  match_ctrl_t         ctrl,
    input  logic [7:0]          ch,
    output logic [KW_COUNT-1:0] seen
);

    for (genvar k = 0; k < KW_COUNT; k++) begin : g_lane
        logic [PROG_W-1:0] prog_reg;
        logic              seen_reg;
        logic [PROG_W-1:0] p_cur;
        logic [PROG_W-1:0] p_hit;
        logic              found;
        logic [PROG_W-1:0] prog_next;

        // Advance on a matching character, restart on the first letter otherwise
        always_comb begin
            p_cur = (prog_reg >= KW_LEN[k]) ? '0 : prog_reg;
            if (KW_TEXT[k][p_cur] == ch) begin
                p_hit = p_cur + PROG_W'(1);
            end else if (KW_TEXT[k][0] == ch) begin
                p_hit = PROG_W'(1);
            end else begin
                p_hit = '0;
            end
            found     = (p_hit >= KW_LEN[k]);
            prog_next = found ? '0 : p_hit;
        end

        // Hold progress and seen flag; clear at line end
        always_ff @(posedge aclk) begin
            if (!aresetn || ctrl.clear) begin
                prog_reg <= '0;
                seen_reg <= 1'b0;
            end else if (ctrl.feed) begin
                prog_reg <= prog_next;
                if (found) begin
                    seen_reg <= 1'b1;
                end
            end
        end

        assign seen[k] = seen_reg;
    end

endmodule

/* hdl/serial_command_line_reader_unit.sv */
// Top level of the serial command line reader: line tracking and result output.
// Depends on sclr_pkg and sclr_matcher.
//
//  channel | dir | tdata                                          | tuser
//  --------+-----+------------------------------------------------+--------------
//  s_      | in  | [7:0] rx_byte                                  | -
//  m_      | out | [5:0] line_length, [6] version_asked,          | [0] result_kind
//          |     | [7] sensor_enabled                             |
//
// One item per cycle: each byte is decoded by single-level logic that updates
// the line state and keyword matchers at the accept edge. A two-deep output
// register (main plus skid) takes each result into main, or into skid while
// main waits; it keeps s_tready high while one result waits, and s_tready
// drops only while the skid stage is full, until m_ takes an item. Reset
// (aresetn low, synchronous) clears the line state and the sensor flag.

module serial_command_line_reader_unit
    import sclr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [5:0] line_length, [6] version_asked, [7] sensor_enabled
    output logic       m_tuser    // [0] result_kind
);

    localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // Line state
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                comment_reg, comment_next;
    logic                semi_reg, semi_next;
    logic                zero_reg, zero_next;
    logic                sensor_reg, sensor_next;

    // Output registers
    result_t             out_reg, skid_reg;
    logic                out_valid_reg, skid_valid_reg;

    // Decode
    logic                accept;
    logic                res_valid;
    result_t             res;
    logic [7:0]          ch_up;
    logic [EXT_W-1:0]    count_ext;
    logic [LEN_W-1:0]    len_sat;
    match_ctrl_t         mctrl;
    logic [KW_COUNT-1:0] seen;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // Saturate the stored count to the length field
    assign count_ext = EXT_W'(count_reg);
    assign len_sat   = (count_ext > EXT_W'(LEN_MAX)) ? LEN_W'(LEN_MAX) : count_ext[LEN_W-1:0];

    // Fold lowercase to uppercase
    assign ch_up = (s_tdata >= CH_LOW_A && s_tdata <= CH_LOW_Z) ? (s_tdata - CASE_OFS) : s_tdata;

    sclr_matcher u_matcher (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mctrl),
        .ch      (ch_up),
        .seen    (seen)
    );

    // Classify the byte and work out the next line state
    always_comb begin
        count_next   = count_reg;
        comment_next = comment_reg;
        semi_next    = semi_reg;
        zero_next    = zero_reg;
        sensor_next  = sensor_reg;
        mctrl        = '0;
        res_valid    = 1'b0;
        res.kind     = KIND_EOL;
        res.length   = len_sat;
        res.version  = 1'b0;
        res.sensor   = sensor_reg;
        if (accept) begin
            if (s_tdata == CH_LF || s_tdata == CH_CR) begin
                // End of line: apply commands of a non-empty line, then clear
                if (count_reg != '0) begin
                    res.version = seen[KW_VER];
                    if (seen[KW_ON]) begin
                        sensor_next = 1'b1;
                    end
                    if (seen[KW_OFF]) begin
                        sensor_next = 1'b0;
                    end
                end
                res.sensor   = sensor_next;
                res_valid    = 1'b1;
                count_next   = '0;
                comment_next = 1'b0;
                semi_next    = 1'b0;
                zero_next    = 1'b0;
                mctrl.clear  = 1'b1;
            end else if (comment_reg || semi_reg) begin
                // Skip; a close paren ends only the comment
                if (s_tdata == CH_RPAREN) begin
                    comment_next = 1'b0;
                end
            end else if (s_tdata == CH_SLASH) begin
                // Drop
            end else if (s_tdata == CH_TILDE) begin
                comment_next = 1'b1;
            end else if (s_tdata == CH_SEMI) begin
                semi_next = 1'b1;
            end else if (count_reg == CNT_W'(LINE_CAPACITY - 1)) begin
                // Line full: drop the byte and report overflow
                res.kind     = KIND_OVERFLOW;
                res_valid    = 1'b1;
                comment_next = 1'b0;
                semi_next    = 1'b0;
            end else begin
                // Store; a zero byte stops matching for the rest of the line
                count_next = count_reg + CNT_W'(1);
                if (ch_up == CH_NUL) begin
                    zero_next = 1'b1;
                end
                mctrl.feed = !(zero_reg || ch_up == CH_NUL);
            end
        end
    end

    // Hold the line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            comment_reg <= 1'b0;
            semi_reg    <= 1'b0;
            zero_reg    <= 1'b0;
            sensor_reg  <= 1'b0;
        end else begin
            count_reg   <= count_next;
            comment_reg <= comment_next;
            semi_reg    <= semi_next;
            zero_reg    <= zero_next;
            sensor_reg  <= sensor_next;
        end
    end

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_tready) begin
            if (res_valid) begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_reg        <= skid_reg;
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_reg       <= res;
            out_valid_reg <= res_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {out_reg.sensor, out_reg.version, out_reg.length};

    // The skid stage fills only behind a waiting main register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid item held without a main item");

    // A line end leaves an empty line behind it
    a_eol_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_tdata == CH_LF || s_tdata == CH_CR) |=> count_reg == '0 && !comment_reg
        && !semi_reg && !zero_reg)
        else $error("line state not cleared after line end");

    // The stored count never passes the line capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LINE_CAPACITY - 1))
        else $error("stored count beyond line capacity");

    // An overflow item never claims a version request
    a_overflow_no_ver: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.kind == KIND_OVERFLOW |-> !res.version)
        else $error("overflow item carries a version request");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for serial_command_line_reader_unit: streams bytes, predicts each result.
// Depends on sclr_pkg (constants, result_t) and the unit under test.

module testbench;
    import sclr_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 16;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] rx_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [5:0] line_length, [6] version_asked, [7] sensor_enabled
    logic       m_tuser;            // [0] result_kind

    // Keyword spellings, as the block is meant to search for them
    logic [7:0] kw_bytes [KW_COUNT][11] = '{
        '{8'h56, 8'h45, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h53, 8'h31, 8'h38, 8'h42, 8'h32, 8'h30, 8'h5F, 8'h4F, 8'h4E, 8'h00},
        '{8'h44, 8'h53, 8'h31, 8'h38, 8'h42, 8'h32, 8'h30, 8'h5F, 8'h4F, 8'h46, 8'h46}
    };
    int kw_size [KW_COUNT] = '{3, 10, 11};
    string plain_chars = "VERDSONF18B20_verdsonf xyzAQ9";

    // Line state of the predictor
    int         line_chars;
    bit         skip_comment;
    bit         skip_rest;
    bit         zero_seen;
    logic [3:0] kw_prog [KW_COUNT];
    bit         kw_found [KW_COUNT];
    bit         sensor_on;

    result_t expected_results [$];
    result_t oldest_result;

    int bytes_sent;
    int error_count;
    int quiet_cycles;
    int src_idle_pct;
    int sink_idle_pct;
    int hold_requests;
    int holds_served;
    int hold_left;

    serial_command_line_reader_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [LEN_W-1:0] clip_len(input int n);
        return (n > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(n);
    endfunction

    function automatic void start_line();
        line_chars   = 0;
        skip_comment = 1'b0;
        skip_rest    = 1'b0;
        zero_seen    = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            kw_prog[k]  = '0;
            kw_found[k] = 1'b0;
        end
    endfunction

    // Advance the line state by one byte; return 1 when it yields a result
    function automatic bit predict_reply(input logic [7:0] rx, output result_t want);
        logic [7:0] ch;
        logic [3:0] p;
        bit         reply;
        ch    = rx;
        reply = 1'b0;
        want  = '0;
        if (ch == CH_LF || ch == CH_CR) begin
            want.kind    = KIND_EOL;
            want.length  = clip_len(line_chars);
            want.version = 1'b0;
            // apply ON first, then OFF, only for a line with content
            if (line_chars > 0) begin
                want.version = kw_found[KW_VER];
                if (kw_found[KW_ON])
                    sensor_on = 1'b1;
                if (kw_found[KW_OFF])
                    sensor_on = 1'b0;
            end
            want.sensor = sensor_on;
            start_line();
            reply = 1'b1;
        end else if (skip_comment || skip_rest) begin
            // a close paren ends a comment but not the rest-of-line skip
            if (ch == CH_RPAREN)
                skip_comment = 1'b0;
        end else if (ch == CH_SLASH) begin
            // drop
        end else if (ch == CH_TILDE) begin
            skip_comment = 1'b1;
        end else if (ch == CH_SEMI) begin
            skip_rest = 1'b1;
        end else if (line_chars >= LINE_CAPACITY - 1) begin
            skip_comment = 1'b0;
            skip_rest    = 1'b0;
            want.kind    = KIND_OVERFLOW;
            want.length  = clip_len(line_chars);
            want.version = 1'b0;
            want.sensor  = sensor_on;
            reply        = 1'b1;
        end else begin
            if (ch >= CH_LOW_A && ch <= CH_LOW_Z)
                ch = ch - CASE_OFS;
            line_chars++;
            if (ch == CH_NUL)
                zero_seen = 1'b1;
            // streaming match; no keyword overlaps itself, so restart on first letter
            if (!zero_seen) begin
                for (int k = 0; k < KW_COUNT; k++) begin
                    p = kw_prog[k];
                    if (p >= kw_size[k])
                        p = '0;
                    if (kw_bytes[k][p] == ch)
                        p = p + 4'd1;
                    else
                        p = (kw_bytes[k][0] == ch) ? 4'd1 : 4'd0;
                    if (p >= kw_size[k]) begin
                        kw_found[k] = 1'b1;
                        p = '0;
                    end
                    kw_prog[k] = p;
                end
            end
        end
        return reply;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_error(input string msg);
        if (error_count < 100)
            $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                flag_error($sformatf("result with none expected: tdata %h tuser %b",
                                     m_tdata, m_tuser));
            end else begin
                oldest_result = expected_results.pop_front();
                if (m_tuser !== oldest_result.kind)
                    flag_error($sformatf("result_kind %b, expected %b",
                                         m_tuser, oldest_result.kind));
                if (m_tdata[5:0] !== oldest_result.length)
                    flag_error($sformatf("line_length %0d, expected %0d",
                                         m_tdata[5:0], oldest_result.length));
                if (m_tdata[6] !== oldest_result.version)
                    flag_error($sformatf("version_asked %b, expected %b",
                                         m_tdata[6], oldest_result.version));
                if (m_tdata[7] !== oldest_result.sensor)
                    flag_error($sformatf("sensor_enabled %b, expected %b",
                                         m_tdata[7], oldest_result.sensor));
            end
        end
    end

    // End the run if neither side moves an item for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Offer one byte, wait for its acceptance, then predict its result
    task automatic send_byte(input logic [7:0] b);
        result_t want;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (predict_reply(b, want))
            expected_results.push_back(want);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_line_text(input string s, input logic [7:0] term);
        send_text(s);
        send_byte(term);
    endtask

    // Send the first n letters of a keyword, optionally in lowercase
    task automatic send_keyword(input int k, input int n, input bit lower);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = kw_bytes[k][i];
            if (lower && b >= UPPER_A && b <= UPPER_Z)
                b = b + CASE_OFS;
            send_byte(b);
        end
    endtask

    function automatic logic [7:0] pick_plain();
        return plain_chars[$urandom_range(0, plain_chars.len() - 1)];
    endfunction

    task automatic send_fill(input int n);
        repeat (n) send_byte(pick_plain());
    endtask

    // Hold the input idle until every expected result has come out
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // One fragment of a line: mostly keywords and text, some skips and noise
    task automatic send_piece();
        int         sel;
        int         k;
        int         cut;
        logic [7:0] b;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            k   = $urandom_range(0, KW_COUNT - 1);
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, kw_size[k] - 1) : kw_size[k];
            for (int i = 0; i < cut; i++) begin
                b = kw_bytes[k][i];
                if (b >= UPPER_A && b <= UPPER_Z && $urandom_range(0, 1) == 1)
                    b = b + CASE_OFS;
                if ($urandom_range(0, 19) == 0)
                    send_byte(CH_SLASH);
                send_byte(b);
            end
        end else if (sel < 55) begin
            send_byte(pick_plain());
        end else if (sel < 62) begin
            send_byte(CH_TILDE);
            repeat ($urandom_range(0, 3)) send_byte(pick_plain());
            if ($urandom_range(0, 9) < 7)
                send_byte(CH_RPAREN);
        end else if (sel < 66) begin
            send_byte(CH_SEMI);
        end else if (sel < 69) begin
            send_byte(CH_RPAREN);
        end else if (sel < 71) begin
            send_byte(CH_NUL);
        end else if (sel < 78) begin
            send_byte(8'($urandom_range(128, 255)));
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_line(input int fill, input int pieces);
        send_fill(fill);
        repeat (pieces) send_piece();
        send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    endtask

    task automatic send_random_line();
        send_line(($urandom_range(0, 19) == 0) ? $urandom_range(50, 70) : 0,
                  $urandom_range(0, 6));
    endtask

    // ---------------------------------------------------------------- tests

    // Empty lines, case folding, slash, skips, zero and high bytes
    task automatic test_directed();
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_line_text("v/eR", CH_CR);
        send_byte(CH_NUL);
        send_byte(8'hFF);
        send_line_text(";)A", CH_CR);
        send_text("~q)");
        send_byte(8'h80);
        send_byte(CH_LF);
    endtask

    // Sensor flag order, keyword restart, comments and a slash inside keywords, zero byte ahead of keywords
    task automatic test_keywords();
        send_keyword(KW_ON, kw_size[KW_ON], 1'b1);
        send_byte(CH_CR);
        send_text("VER ");
        send_keyword(KW_OFF, kw_size[KW_OFF], 1'b0);
        send_byte(CH_LF);
        send_keyword(KW_ON, kw_size[KW_ON], 1'b0);
        send_keyword(KW_OFF, kw_size[KW_OFF], 1'b0);
        send_byte(CH_CR);
        send_text("d");
        send_keyword(KW_ON, kw_size[KW_ON], 1'b1);
        send_byte(CH_LF);
        send_keyword(KW_OFF, kw_size[KW_OFF] - 2, 1'b0);
        send_line_text("~x)FF", CH_CR);
        send_byte(CH_NUL);
        send_text("VER ");
        send_keyword(KW_ON, kw_size[KW_ON], 1'b0);
        send_byte(CH_LF);
        send_keyword(KW_ON, kw_size[KW_ON] - 2, 1'b0);
        send_byte(CH_SLASH);
        send_text("ON;");
        send_keyword(KW_OFF, kw_size[KW_OFF], 1'b0);
        send_byte(CH_LF);
        send_byte(CH_CR);
        repeat (12) send_random_line();
    endtask

    // Full lines, overflow, and skips on a full line
    task automatic test_long_lines();
        send_line(63, 0);
        send_fill(63);
        send_text("X~Y)Z;Q");
        send_byte(CH_LF);
        repeat (5) send_line($urandom_range(56, 70), $urandom_range(0, 4));
    endtask

    // Stall the receiver long enough to fill the output stage, then drain
    task automatic test_backpressure();
        hold_requests++;
        repeat (20) send_line_text("ver", CH_LF);
        wait_for_results();
        repeat (6) send_random_line();
    endtask

    task automatic test_random(input int n);
        int target;
        target = bytes_sent + n;
        while (bytes_sent < target)
            send_random_line();
    endtask

    initial begin
        start_line();
        sensor_on = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct  = 15;
        sink_idle_pct = 87;
        test_directed();
        test_keywords();
        test_random(200);

        src_idle_pct  = 87;
        sink_idle_pct = 15;
        test_long_lines();
        test_random(200);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_backpressure();
        test_random(200);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
